// ===== sv/unsigned_to_ascii_digits_macros.svh =====
// assertion macros for the unsigned to ascii digits block
// used by the top level only, needs no package
`ifndef UNSIGNED_TO_ASCII_DIGITS_MACROS_SVH
`define UNSIGNED_TO_ASCII_DIGITS_MACROS_SVH

// same-cycle implication, checked outside reset
`define U2A_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication, checked outside reset
`define U2A_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== sv/u2a_pkg.sv =====
// shared types, constants and the digit to ascii lookup
// for the unsigned to ascii digits block; no dependencies
`default_nettype none

package u2a_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int MAX_DIGITS  = (VALUE_WIDTH + 2) / 3;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int REM_W       = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_W      = 7;
    localparam int COUNT_W     = 4;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // register index field of paddr
    localparam logic [PADDR_W-3:0] REG_RADIX_MODE = '0;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;

    typedef enum logic [1:0] {
        RADIX_DEC       = 2'd0,
        RADIX_OCT       = 2'd1,
        RADIX_HEX_LOWER = 2'd2,
        RADIX_HEX_UPPER = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_HOLD
    } conv_state_t;

    typedef logic [3:0] digit_t;

    // converter to emitter handoff
    typedef struct packed {
        logic                           valid;
        logic                           upper;
        logic [MAX_DIGITS-1:0][3:0]     digits;
    } conv_result_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(digit_t d, logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else if (upper) begin
            c = ASCII_UPPER_A + CHAR_W'(d - 4'd10);
        end else begin
            c = ASCII_LOWER_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/u2a_cfg.sv =====
// apb-style register port holding the radix mode
// depends on u2a_pkg
`default_nettype none

module u2a_cfg import u2a_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output radix_t                  radix_mode
);

    radix_t radix_reg;
    radix_t radix_next;
    logic   hit;

    assign hit    = (paddr[PADDR_W-1:2] == REG_RADIX_MODE);
    assign pready = 1'b1;

    always_comb begin
        radix_next = radix_reg;
        if (psel && penable && pwrite && hit) begin
            radix_next = radix_t'(pwdata[1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_DEC;
        end else begin
            radix_reg <= radix_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = PDATA_W'(radix_reg);
        end
    end

    assign radix_mode = radix_reg;

endmodule

`default_nettype wire

// ===== sv/u2a_conv.sv =====
// bit-serial shift-and-adjust converter: one value bit per cycle into a digit register
// depends on u2a_pkg
`default_nettype none

module u2a_conv import u2a_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [IN_W-1:0] s_value,
    input  wire radix_t          radix_mode,
    input  wire logic            take,
    output conv_result_t         result
);

    conv_state_t state_reg;
    conv_state_t state_next;

    logic [CNT_W-1:0]           cnt_reg;
    logic [VALUE_WIDTH-1:0]     value_reg;
    logic [MAX_DIGITS-1:0][3:0] digits_reg;
    logic [MAX_DIGITS-1:0][3:0] digits_next;
    radix_t                     mode_reg;
    logic [MAX_DIGITS:0]        carry;
    logic                       accept;

    assign accept = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CONV_IDLE: begin
                if (s_valid) state_next = CONV_SHIFT;
            end
            CONV_SHIFT: begin
                if (cnt_reg == CNT_W'(1)) state_next = CONV_HOLD;
            end
            CONV_HOLD: begin
                if (take) state_next = CONV_IDLE;
            end
            default: state_next = CONV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = (state_reg == CONV_IDLE);
        result.valid  = (state_reg == CONV_HOLD);
        result.upper  = (mode_reg == RADIX_HEX_UPPER);
        result.digits = digits_reg;
    end

    // each digit's carry out depends only on its own old value, so the chain is shallow
    always_comb begin
        digit_t adj;
        carry[0] = value_reg[VALUE_WIDTH-1];
        for (int i = 0; i < MAX_DIGITS; i++) begin
            adj = digits_reg[i];
            case (mode_reg)
                RADIX_DEC: begin
                    if (digits_reg[i] >= 4'd5) adj = digits_reg[i] + 4'd3;
                    carry[i+1]     = adj[3];
                    digits_next[i] = {adj[2:0], carry[i]};
                end
                RADIX_OCT: begin
                    carry[i+1]     = adj[2];
                    digits_next[i] = {1'b0, adj[1:0], carry[i]};
                end
                default: begin
                    carry[i+1]     = adj[3];
                    digits_next[i] = {adj[2:0], carry[i]};
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg  <= VALUE_WIDTH'(s_value);
            digits_reg <= '0;
            cnt_reg    <= CNT_W'(VALUE_WIDTH);
            mode_reg   <= radix_mode;
        end else if (state_reg == CONV_SHIFT) begin
            value_reg  <= {value_reg[VALUE_WIDTH-2:0], 1'b0};
            digits_reg <= digits_next;
            cnt_reg    <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== sv/u2a_emit.sv =====
// digit emitter: shifts digits out most significant first, drops leading zeros
// and drives the result output register; depends on u2a_pkg
`default_nettype none

module u2a_emit import u2a_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire conv_result_t        result,
    output logic                     take,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [CHAR_W-1:0]        m_digit_char,
    output logic [COUNT_W-1:0]       m_digit_count,
    output logic                     m_last_digit
);

    logic                       busy_reg,    busy_next;
    logic                       started_reg, started_next;
    logic [REM_W-1:0]           rem_reg,     rem_next;
    logic [COUNT_W-1:0]         count_reg,   count_next;
    logic                       m_valid_reg, m_valid_next;
    logic [MAX_DIGITS-1:0][3:0] dig_reg;
    logic                       upper_reg;
    logic [CHAR_W-1:0]          char_reg;
    logic [COUNT_W-1:0]         mcount_reg;
    logic                       last_reg;

    logic   step;
    logic   final_slot;
    logic   show;
    digit_t top;

    assign take       = result.valid && !busy_reg;
    assign step       = busy_reg && (!m_valid_reg || m_ready);
    assign top        = dig_reg[MAX_DIGITS-1];
    assign final_slot = (rem_reg == REM_W'(1));
    // the least significant slot always shows, so zero gives a single '0'
    assign show       = (top != 4'd0) || started_reg || final_slot;

    always_comb begin
        busy_next    = busy_reg;
        started_next = started_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (take) begin
            busy_next    = 1'b1;
            started_next = 1'b0;
            rem_next     = REM_W'(MAX_DIGITS);
            count_next   = '0;
        end else if (step) begin
            rem_next = rem_reg - REM_W'(1);
            if (final_slot) busy_next = 1'b0;
            if (show) begin
                started_next = 1'b1;
                count_next   = count_reg + COUNT_W'(1);
            end
        end
        if (step) begin
            m_valid_next = show;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            started_reg <= 1'b0;
            rem_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            started_reg <= started_next;
            rem_reg     <= rem_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            dig_reg   <= result.digits;
            upper_reg <= result.upper;
        end else if (step) begin
            dig_reg <= {dig_reg[MAX_DIGITS-2:0], 4'h0};
        end
        if (step && show) begin
            char_reg   <= digit_to_char(top, upper_reg);
            mcount_reg <= count_reg + COUNT_W'(1);
            last_reg   <= final_slot;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digit_char  = char_reg;
    assign m_digit_count = mcount_reg;
    assign m_last_digit  = last_reg;

endmodule

`default_nettype wire

// ===== sv/unsigned_to_ascii_digits.sv =====
// after a request is accepted, the bit-serial converter shifts in one value bit per cycle,
// then the emitter takes the result, skips leading zeros and shows the first digit
// the converter can accept a new value once the emitter has taken the last result,
// while its digits are still shown; digits leave at one per cycle while m_ready stays high
// reset: aresetn synchronous active low, clears control and sets radix mode to decimal
`default_nettype none
`include "unsigned_to_ascii_digits_macros.svh"

module unsigned_to_ascii_digits import u2a_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [IN_W-1:0]    s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CHAR_W-1:0]       m_digit_char,
    output logic [COUNT_W-1:0]      m_digit_count,
    output logic                    m_last_digit,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    radix_t       radix_mode;
    conv_result_t conv_result;
    logic         take;

    u2a_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .radix_mode (radix_mode)
    );

    u2a_conv u_conv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .radix_mode (radix_mode),
        .take       (take),
        .result     (conv_result)
    );

    u2a_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .result        (conv_result),
        .take          (take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit_char  (m_digit_char),
        .m_digit_count (m_digit_count),
        .m_last_digit  (m_last_digit)
    );

    // converter is busy shifting once a request is taken
    `U2A_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // every character shown is a legal digit of one of the forms
    `U2A_ASSERT_NOW(a_char_legal, aclk, aresetn, m_valid,
        (m_digit_char >= 7'h30 && m_digit_char <= 7'h39) ||
        (m_digit_char >= 7'h41 && m_digit_char <= 7'h46) ||
        (m_digit_char >= 7'h61 && m_digit_char <= 7'h66))

    // leading zeros are suppressed unless the value is zero itself
    `U2A_ASSERT_NOW(a_no_leading_zero, aclk, aresetn,
        m_valid && (m_digit_count == 4'd1) && !m_last_digit, m_digit_char != 7'h30)

endmodule

`default_nettype wire
